/* design/positioned_reader_cache_lru_top_defines.svh */
// Assertion helpers shared by the cache modules.
`ifndef POSITIONED_READER_CACHE_LRU_TOP_DEFINES_SVH
`define POSITIONED_READER_CACHE_LRU_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRC_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("cache assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PRC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("cache assertion failed");

`endif

/* design/prc_pkg.sv */
package prc_pkg;

    localparam int SLOTS_DEFAULT = 8;
    localparam int INDEX_W       = 32;
    localparam int OFFSET_W      = 48;
    localparam int AGE_W         = 64;
    localparam int SLOT_W        = 3;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic ACT_ACQUIRE = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    typedef struct packed {
        logic                is_release;
        logic [INDEX_W-1:0]  index;
        logic [OFFSET_W-1:0] offset;
    } req_t;

    typedef struct packed {
        logic valid;
        req_t req;
    } queue_head_t;

    typedef struct packed {
        logic                done;
        logic                hit;
        logic [SLOT_W-1:0]   slot;
        logic [INDEX_W-1:0]  found_index;
        logic [OFFSET_W-1:0] found_offset;
        logic                evicted;
    } result_t;

endpackage

/* design/positioned_reader_cache_lru_top.sv */
// Saved-position cache with least-recently-used replacement.
// Request channel: drive action, entry_index and entry_offset with start high;
// the request is taken at a rising edge where start is high and busy is low.
// action 0 acquires the greatest saved position not beyond (entry_index, 0)
// and frees its slot; action 1 stores (entry_index, entry_offset) in the
// oldest slot. Requests enter a two-deep queue; busy is high only while the
// queue is full.
// Result channel: done is high for one cycle with hit, slot, found_index,
// found_offset and evicted valid in that cycle. There is no back-pressure;
// the receiver must take each result in the cycle it appears.
// Timing: the back end scans the table one slot per cycle, one candidate at
// a time against the running best, and finishes each request before it
// pops the next from the queue. Results come out in request order.
// Reset: rst_n clears the queue, all slot valid bits and the age counter;
// no clearing pass is needed and the first request can follow at once.
module positioned_reader_cache_lru_top #(
    parameter int SLOTS = prc_pkg::SLOTS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          action,
    input  logic [prc_pkg::INDEX_W-1:0]   entry_index,
    input  logic [prc_pkg::OFFSET_W-1:0]  entry_offset,
    output logic                          done,
    output logic                          hit,
    output logic [prc_pkg::SLOT_W-1:0]    slot,
    output logic [prc_pkg::INDEX_W-1:0]   found_index,
    output logic [prc_pkg::OFFSET_W-1:0]  found_offset,
    output logic                          evicted
);
    import prc_pkg::*;

    queue_head_t head;
    logic        pop;
    result_t     result;

    prc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .action       (action),
        .entry_index  (entry_index),
        .entry_offset (entry_offset),
        .pop          (pop),
        .busy         (busy),
        .head         (head)
    );

    prc_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .result (result)
    );

    assign done         = result.done;
    assign hit          = result.hit;
    assign slot         = result.slot;
    assign found_index  = result.found_index;
    assign found_offset = result.found_offset;
    assign evicted      = result.evicted;

endmodule

/* design/prc_front.sv */
`include "positioned_reader_cache_lru_top_defines.svh"

module prc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          action,
    input  logic [prc_pkg::INDEX_W-1:0]   entry_index,
    input  logic [prc_pkg::OFFSET_W-1:0]  entry_offset,
    input  logic                          pop,
    output logic                          busy,
    output prc_pkg::queue_head_t          head
);
    import prc_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    req_t          queue_mem [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          push;
    req_t          req_in;

    assign busy = (count_reg == CW'(QUEUE_DEPTH));
    assign push = start && !busy;

    // classify the request before it is queued
    always_comb
    begin
        req_in.is_release = (action == ACT_RELEASE);
        req_in.index      = entry_index;
        req_in.offset     = entry_offset;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= req_in;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.req   = queue_mem[rd_ptr_reg];

    `PRC_ASSERT_IMPL(a_queue_bound, clk, rst_n, 1'b1, count_reg <= CW'(QUEUE_DEPTH))
    `PRC_ASSERT_IMPL(a_pop_nonempty, clk, rst_n, pop, count_reg != '0)
    `PRC_ASSERT_NEXT(a_push_grows, clk, rst_n, push && !pop, count_reg == $past(count_reg) + CW'(1))

endmodule

/* design/prc_back.sv */
`include "positioned_reader_cache_lru_top_defines.svh"

module prc_back #(
    parameter int SLOTS = prc_pkg::SLOTS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  prc_pkg::queue_head_t  head,
    output logic                  pop,
    output prc_pkg::result_t      result
);
    import prc_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    // position and age storage, one read and one write port
    logic [INDEX_W-1:0]  index_mem  [SLOTS];
    logic [OFFSET_W-1:0] offset_mem [SLOTS];
    logic [AGE_W-1:0]    age_mem    [SLOTS];

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [CW-1:0]       cnt_reg;
    logic [CW-1:0]       cnt_next;
    req_t                req_reg;
    req_t                req_next;
    logic [SLOTS-1:0]    valid_reg;
    logic [SLOTS-1:0]    valid_next;
    logic [AGE_W-1:0]    age_counter_reg;
    logic [AGE_W-1:0]    age_counter_next;
    result_t             result_reg;
    result_t             result_next;

    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                rd_live_reg;
    logic [AW-1:0]       rd_slot_reg;
    logic [INDEX_W-1:0]  rd_index_reg;
    logic [OFFSET_W-1:0] rd_offset_reg;
    logic [AGE_W-1:0]    rd_age_reg;

    logic                best_have_reg;
    logic                best_have_next;
    logic                best_valid_reg;
    logic                best_valid_next;
    logic [AW-1:0]       best_slot_reg;
    logic [AW-1:0]       best_slot_next;
    logic [INDEX_W-1:0]  best_index_reg;
    logic [INDEX_W-1:0]  best_index_next;
    logic [OFFSET_W-1:0] best_offset_reg;
    logic [OFFSET_W-1:0] best_offset_next;
    logic [AGE_W-1:0]    best_age_reg;
    logic [AGE_W-1:0]    best_age_next;

    logic                cand_valid;
    logic [AGE_W-1:0]    cand_age;
    logic                fits;
    logic                beats;
    logic                take;
    logic                wr_en;
    logic                hit;

    assign rd_en   = (state_reg == ST_SCAN) && (cnt_reg < CW'(SLOTS));
    assign rd_addr = cnt_reg[AW-1:0];
    assign wr_en   = (state_reg == ST_UPDATE) && req_reg.is_release;
    assign hit     = !req_reg.is_release && best_have_reg;

    // one candidate per cycle against the running best
    always_comb
    begin
        cand_valid = valid_reg[rd_slot_reg];
        // an empty slot always carries age zero
        cand_age   = cand_valid ? rd_age_reg : '0;
        fits       = cand_valid && ((rd_index_reg < req_reg.index) ||
                     ((rd_index_reg == req_reg.index) && (rd_offset_reg == '0)));
        beats      = (rd_index_reg > best_index_reg) ||
                     ((rd_index_reg == best_index_reg) && (rd_offset_reg > best_offset_reg));
        if (req_reg.is_release)
        begin
            take = rd_live_reg && (!best_have_reg || (cand_age < best_age_reg));
        end
        else
        begin
            take = rd_live_reg && fits && (!best_have_reg || beats);
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        req_next         = req_reg;
        valid_next       = valid_reg;
        age_counter_next = age_counter_reg;
        result_next      = result_reg;
        result_next.done = 1'b0;
        pop              = 1'b0;
        best_have_next   = best_have_reg;
        best_valid_next  = best_valid_reg;
        best_slot_next   = best_slot_reg;
        best_index_next  = best_index_reg;
        best_offset_next = best_offset_reg;
        best_age_next    = best_age_reg;

        if (take)
        begin
            best_have_next   = 1'b1;
            best_valid_next  = cand_valid;
            best_slot_next   = rd_slot_reg;
            best_index_next  = rd_index_reg;
            best_offset_next = rd_offset_reg;
            best_age_next    = cand_age;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop            = 1'b1;
                    req_next       = head.req;
                    cnt_next       = '0;
                    best_have_next = 1'b0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == CW'(SLOTS))
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_UPDATE:
            begin
                result_next.done         = 1'b1;
                result_next.hit          = hit;
                result_next.slot         = (hit || req_reg.is_release) ?
                                           SLOT_W'(best_slot_reg) : '0;
                result_next.found_index  = hit ? best_index_reg : '0;
                result_next.found_offset = hit ? best_offset_reg : '0;
                result_next.evicted      = req_reg.is_release && best_valid_reg;
                if (req_reg.is_release)
                begin
                    valid_next[best_slot_reg] = 1'b1;
                    age_counter_next          = age_counter_reg + AGE_W'(1);
                end
                else if (best_have_reg)
                begin
                    valid_next[best_slot_reg] = 1'b0;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            valid_reg       <= '0;
            age_counter_reg <= '0;
            result_reg      <= '0;
            rd_live_reg     <= 1'b0;
            best_have_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            valid_reg       <= valid_next;
            age_counter_reg <= age_counter_next;
            result_reg      <= result_next;
            rd_live_reg     <= rd_en;
            best_have_reg   <= best_have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        best_valid_reg  <= best_valid_next;
        best_slot_reg   <= best_slot_next;
        best_index_reg  <= best_index_next;
        best_offset_reg <= best_offset_next;
        best_age_reg    <= best_age_next;
        rd_slot_reg     <= rd_addr;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_index_reg  <= index_mem[rd_addr];
            rd_offset_reg <= offset_mem[rd_addr];
            rd_age_reg    <= age_mem[rd_addr];
        end
        if (wr_en)
        begin
            index_mem[best_slot_reg]  <= req_reg.index;
            offset_mem[best_slot_reg] <= req_reg.offset;
            age_mem[best_slot_reg]    <= age_counter_reg + AGE_W'(1);
        end
    end

    assign result = result_reg;

    `PRC_ASSERT_NEXT(a_done_single, clk, rst_n, result_reg.done, !result_reg.done)
    `PRC_ASSERT_IMPL(a_release_found, clk, rst_n, wr_en, best_have_reg)
    `PRC_ASSERT_NEXT(a_age_step, clk, rst_n, wr_en, age_counter_reg == $past(age_counter_reg) + AGE_W'(1))
    `PRC_ASSERT_NEXT(a_hit_frees, clk, rst_n, (state_reg == ST_UPDATE) && hit, !valid_reg[$past(best_slot_reg)])

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;

    import prc_pkg::*;

    localparam int SLOTS        = SLOTS_DEFAULT;
    localparam int RANDOM_ITEMS = 1300;

    // Table of saved positions, predicted alongside the block; results are
    // queued in request order and compared as they come out.
    class saved_position_table;
        bit                valid [SLOTS];
        bit [INDEX_W-1:0]  index [SLOTS];
        bit [OFFSET_W-1:0] offset [SLOTS];
        bit [AGE_W-1:0]    age [SLOTS];
        bit [AGE_W-1:0]    age_counter;
        result_t           expected_results[$];
        int                mismatches;

        function new();
            for (int k = 0; k < SLOTS; k++)
            begin
                valid[k]  = 1'b0;
                index[k]  = '0;
                offset[k] = '0;
                age[k]    = '0;
            end
            age_counter = '0;
            mismatches  = 0;
        endfunction

        function void note_request(logic act, logic [INDEX_W-1:0] idx,
                                   logic [OFFSET_W-1:0] off);
            result_t r;
            bit      have;
            int      best;
            int      oldest;
            r    = '0;
            r.done = 1'b1;
            have = 1'b0;
            best = 0;
            oldest = 0;
            if (act == ACT_ACQUIRE)
            begin
                for (int k = 0; k < SLOTS; k++)
                begin
                    // candidate must not lie beyond (idx, 0)
                    if (valid[k] && {index[k], offset[k]} <= {idx, {OFFSET_W{1'b0}}})
                    begin
                        if (!have || {index[best], offset[best]} < {index[k], offset[k]})
                        begin
                            have = 1'b1;
                            best = k;
                        end
                    end
                end
                if (have)
                begin
                    r.hit          = 1'b1;
                    r.slot         = best[SLOT_W-1:0];
                    r.found_index  = index[best];
                    r.found_offset = offset[best];
                    valid[best]    = 1'b0;
                    age[best]      = '0;
                end
            end
            else
            begin
                for (int k = 1; k < SLOTS; k++)
                    if (age[k] < age[oldest])
                        oldest = k;
                r.slot         = oldest[SLOT_W-1:0];
                r.evicted      = valid[oldest];
                age_counter    = age_counter + 1'b1;
                valid[oldest]  = 1'b1;
                index[oldest]  = idx;
                offset[oldest] = off;
                age[oldest]    = age_counter;
            end
            expected_results.push_back(r);
        endfunction

        function void check_result(logic h, logic [SLOT_W-1:0] s, logic [INDEX_W-1:0] fi,
                                   logic [OFFSET_W-1:0] fo, logic ev);
            result_t e;
            if (expected_results.size() == 0)
            begin
                $error("result with no request outstanding");
                mismatches++;
                return;
            end
            e = expected_results.pop_front();
            if (h !== e.hit)
            begin
                $error("hit: expected %0d, actual %0d", e.hit, h);
                mismatches++;
            end
            if (s !== e.slot)
            begin
                $error("slot: expected %0d, actual %0d", e.slot, s);
                mismatches++;
            end
            if (fi !== e.found_index)
            begin
                $error("found_index: expected %h, actual %h", e.found_index, fi);
                mismatches++;
            end
            if (fo !== e.found_offset)
            begin
                $error("found_offset: expected %h, actual %h", e.found_offset, fo);
                mismatches++;
            end
            if (ev !== e.evicted)
            begin
                $error("evicted: expected %0d, actual %0d", e.evicted, ev);
                mismatches++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                action;
    logic [INDEX_W-1:0]  entry_index;
    logic [OFFSET_W-1:0] entry_offset;
    logic                done;
    logic                hit;
    logic [SLOT_W-1:0]   slot;
    logic [INDEX_W-1:0]  found_index;
    logic [OFFSET_W-1:0] found_offset;
    logic                evicted;

    saved_position_table table_model;

    positioned_reader_cache_lru_top #(
        .SLOTS(SLOTS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .entry_index  (entry_index),
        .entry_offset (entry_offset),
        .done         (done),
        .hit          (hit),
        .slot         (slot),
        .found_index  (found_index),
        .found_offset (found_offset),
        .evicted      (evicted)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            table_model.check_result(hit, slot, found_index, found_offset, evicted);
    end

    // Drive one request; start stays high afterwards until a gap drops it.
    task automatic send_request(logic act, logic [INDEX_W-1:0] idx,
                                logic [OFFSET_W-1:0] off);
        @(negedge clk);
        start        <= 1'b1;
        action       <= act;
        entry_index  <= idx;
        entry_offset <= off;
        do
            @(posedge clk);
        while (busy);
        table_model.note_request(act, idx, off);
    endtask

    task automatic pause_sender(int cycles);
        @(negedge clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    function automatic logic [INDEX_W-1:0] pick_index();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return $urandom_range(0, 15);
        else if (sel < 80)
            return $urandom_range(0, 3);
        else if (sel < 88)
            return 32'hFFFF_FFFF - $urandom_range(0, 3);
        else
            return $urandom;
    endfunction

    function automatic logic [OFFSET_W-1:0] pick_offset();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 35)
            return '0;
        else if (sel < 55)
            return OFFSET_W'($urandom_range(1, 3));
        else if (sel < 65)
            return {OFFSET_W{1'b1}} - OFFSET_W'($urandom_range(0, 3));
        else
            return OFFSET_W'({$urandom, $urandom});
    endfunction

    initial
    begin
        int sent;
        int burst;
        int gap;
        logic act;

        table_model  = new();
        rst_n        = 1'b0;
        start        = 1'b0;
        action       = ACT_ACQUIRE;
        entry_index  = '0;
        entry_offset = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty table misses
        send_request(ACT_ACQUIRE, 32'h0, 48'h0);
        send_request(ACT_ACQUIRE, 32'hFFFF_FFFF, {OFFSET_W{1'b1}});
        // fill every slot, extremes included, one duplicate position
        send_request(ACT_RELEASE, 32'd5, 48'd100);
        send_request(ACT_RELEASE, 32'd5, 48'd0);
        send_request(ACT_RELEASE, 32'd0, 48'd0);
        send_request(ACT_RELEASE, 32'hFFFF_FFFF, {OFFSET_W{1'b1}});
        send_request(ACT_RELEASE, 32'hFFFF_FFFF, 48'd0);
        send_request(ACT_RELEASE, 32'd7, 48'd1);
        send_request(ACT_RELEASE, 32'd5, 48'd100);
        send_request(ACT_RELEASE, 32'd3, {OFFSET_W{1'b1}});
        // table full: oldest slot is overwritten
        send_request(ACT_RELEASE, 32'd9, 48'd9);
        // exact (index, 0) qualifies, nonzero offset at same index does not
        send_request(ACT_ACQUIRE, 32'd5, {OFFSET_W{1'b1}});
        send_request(ACT_ACQUIRE, 32'd4, 48'd0);
        send_request(ACT_ACQUIRE, 32'hFFFF_FFFF, 48'd0);
        send_request(ACT_ACQUIRE, 32'd0, 48'd0);
        send_request(ACT_ACQUIRE, 32'd0, 48'd0);
        // freed slots take new releases; equal positions, lowest slot wins
        send_request(ACT_RELEASE, 32'd6, 48'd6);
        send_request(ACT_RELEASE, 32'd6, 48'd6);
        send_request(ACT_ACQUIRE, 32'd6, 48'd0);
        send_request(ACT_RELEASE, 32'd6, 48'd0);
        send_request(ACT_RELEASE, 32'd6, 48'd0);
        send_request(ACT_ACQUIRE, 32'd7, 48'd0);
        send_request(ACT_ACQUIRE, 32'd7, 48'd0);
        send_request(ACT_ACQUIRE, 32'hFFFF_FFFF, {OFFSET_W{1'b1}});
        pause_sender(3);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 12);
            for (int j = 0; j < burst && sent < RANDOM_ITEMS; j++)
            begin
                act = ($urandom_range(0, 1) == 0) ? ACT_ACQUIRE : ACT_RELEASE;
                send_request(act, pick_index(), pick_offset());
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap != 0)
                pause_sender(gap);
        end

        @(negedge clk);
        start <= 1'b0;
        while (table_model.expected_results.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 8) @(posedge clk);

        if (table_model.mismatches == 0 && table_model.expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
